>>> hw/rtl/ftdp_pkg.sv
// Shared types, result codes and helpers for the FLV tag parser.
`default_nettype none
package ftdp_pkg;

    localparam int OFS_W = 32;

    localparam logic [23:0] SIG_FLV     = 24'h464c56;
    localparam logic [7:0]  STREAM_BITS = 8'h05;
    localparam logic [7:0]  TAG_AUDIO   = 8'h08;
    localparam logic [7:0]  TAG_VIDEO   = 8'h09;
    localparam logic [3:0]  CODEC_AAC   = 4'd10;
    localparam logic [3:0]  CODEC_AVC   = 4'd7;
    localparam logic [3:0]  FRAME_KEY   = 4'd1;
    localparam logic [7:0]  PKT_CONFIG  = 8'd0;
    localparam logic [7:0]  PKT_FRAME   = 8'd1;

    localparam logic [2:0] KIND_AUDIO_FRAME  = 3'd0;
    localparam logic [2:0] KIND_VIDEO_FRAME  = 3'd1;
    localparam logic [2:0] KIND_AUDIO_CONFIG = 3'd2;
    localparam logic [2:0] KIND_VIDEO_CONFIG = 3'd3;
    localparam logic [2:0] KIND_END          = 3'd4;
    localparam logic [2:0] KIND_BAD_SIG      = 3'd5;
    localparam logic [2:0] KIND_NO_STREAM    = 3'd6;
    localparam logic [2:0] KIND_BAD_TAG      = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] payload_offset;
        logic [23:0] payload_length;
        logic [31:0] time_ms;
        logic [31:0] presentation_ms;
        logic        keyframe;
        logic [15:0] config_bits;
        logic [31:0] audio_duration_ms;
        logic [31:0] video_duration_ms;
        logic        final_res;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(
        input logic [2:0]  kind,
        input logic [31:0] offset,
        input logic [23:0] length,
        input logic [31:0] t,
        input logic [31:0] p,
        input logic        key,
        input logic [15:0] cfg,
        input logic [31:0] amax,
        input logic [31:0] vmax
    );
        result_t r;
        r.kind              = kind;
        r.payload_offset    = offset;
        r.payload_length    = length;
        r.time_ms           = t;
        r.presentation_ms   = p;
        r.keyframe          = key;
        r.config_bits       = cfg;
        r.audio_duration_ms = amax;
        r.video_duration_ms = vmax;
        r.final_res         = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/flv_tag_demux_parser_unit.sv
// Top level of the FLV tag parser: byte input channel and descriptor output channel.
//
// The s_ channel takes one FLV file byte per request, with s_last_byte marking
// the final byte. The m_ channel returns descriptors: audio and video frames and
// configs, end of stream, and error codes; m_final_res marks the last result
// caused by one byte. A byte is taken in every cycle while the result queue has
// room for two entries, so the sustained rate is one byte per clock.
// A result enters the queue when its byte is accepted and reaches m_ after
// those ahead of it. The last byte can cause two results, which enter the queue
// together. After an error or the end of the file the block takes bytes but
// produces nothing until reset. Reset (aresetn low at a clock edge) returns the
// parser to the file header and empties the result queue. When the receiver
// stalls, results wait in the four-entry queue; s_ready drops once fewer than
// two entries are free and rises again as results are taken.
`default_nettype none
module flv_tag_demux_parser_unit
    import ftdp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [31:0]      m_payload_offset,
    output logic [23:0]      m_payload_length,
    output logic [31:0]      m_time_ms,
    output logic [31:0]      m_presentation_ms,
    output logic             m_keyframe,
    output logic [15:0]      m_config_bits,
    output logic [31:0]      m_audio_duration_ms,
    output logic [31:0]      m_video_duration_ms,
    output logic             m_final_res
);

    push_t   push;
    result_t head;
    logic    room;

    assign s_ready = room;

    ftdp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && room),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .push      (push)
    );

    ftdp_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (head)
    );

    assign m_kind              = head.kind;
    assign m_payload_offset    = head.payload_offset;
    assign m_payload_length    = head.payload_length;
    assign m_time_ms           = head.time_ms;
    assign m_presentation_ms   = head.presentation_ms;
    assign m_keyframe          = head.keyframe;
    assign m_config_bits       = head.config_bits;
    assign m_audio_duration_ms = head.audio_duration_ms;
    assign m_video_duration_ms = head.video_duration_ms;
    assign m_final_res         = head.final_res;

endmodule
`default_nettype wire

>>> hw/rtl/ftdp_parse.sv
// Per-byte parsing state and descriptor generation for the FLV tag parser.
`default_nettype none
module ftdp_parse
    import ftdp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output push_t           push
);

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_SKIPFIRST,
        PH_TAGHDR,
        PH_SUBHDR,
        PH_SKIPBODY,
        PH_STOP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [OFS_W-1:0]  pos_reg, pos_next;
    logic [4:0]        fidx_reg, fidx_next;
    logic [OFS_W-1:0]  tstart_reg, tstart_next;
    logic [7:0]        tkind_reg, tkind_next;
    logic [23:0]       tsize_reg, tsize_next;
    logic [31:0]       ttime_reg, ttime_next;
    logic [39:0]       sub_reg, sub_next;
    logic [31:0]       skip_reg, skip_next;
    logic [31:0]       amax_reg, amax_next;
    logic [31:0]       vmax_reg, vmax_next;
    push_t             push_next;

    always_comb begin
        logic [39:0]      sh;
        logic [OFS_W-1:0] fto;
        logic [OFS_W-1:0] off;
        logic [23:0]      need;
        logic [4:0]       fi_inc;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [31:0]      pts;
        logic             main_valid;
        result_t          main_res;
        result_t          end_res;
        logic             end_valid;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        fidx_next   = fidx_reg;
        tstart_next = tstart_reg;
        tkind_next  = tkind_reg;
        tsize_next  = tsize_reg;
        ttime_next  = ttime_reg;
        sub_next    = sub_reg;
        skip_next   = skip_reg;
        amax_next   = amax_reg;
        vmax_next   = vmax_reg;
        main_valid  = 1'b0;
        main_res    = make_result(KIND_END, '0, '0, '0, '0, 1'b0, '0, '0, '0);
        end_res     = main_res;
        end_valid   = 1'b0;
        sh          = {sub_reg[31:0], data_byte};
        fto         = OFS_W'(sh[31:0] + 32'd4);
        need        = (tkind_reg == TAG_AUDIO) ? 24'd4 : 24'd5;
        fi_inc      = fidx_reg + 5'd1;
        b0          = '0;
        b1          = '0;
        pts         = '0;
        off         = '0;

        unique case (phase_reg)
            PH_HEAD: begin
                sub_next = sh;
                if (fidx_reg == 5'd2 && sh[23:0] != SIG_FLV) begin
                    main_valid = 1'b1;
                    main_res   = make_result(KIND_BAD_SIG, '0, '0, '0, '0, 1'b0, '0,
                                             amax_reg, vmax_reg);
                    phase_next = PH_STOP;
                end else if (fidx_reg == 5'd4 && (data_byte & STREAM_BITS) != STREAM_BITS)
                begin
                    main_valid = 1'b1;
                    main_res   = make_result(KIND_NO_STREAM, '0, '0, '0, '0, 1'b0, '0,
                                             amax_reg, vmax_reg);
                    phase_next = PH_STOP;
                end else if (fidx_reg == 5'd8) begin
                    if (fto > OFS_W'(9)) begin
                        skip_next  = 32'(fto - OFS_W'(9));
                        phase_next = PH_SKIPFIRST;
                    end else begin
                        phase_next = PH_TAGHDR;
                        fidx_next  = '0;
                    end
                end else begin
                    fidx_next = fi_inc;
                end
            end
            PH_SKIPFIRST, PH_SKIPBODY: begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == '0) begin
                    phase_next = PH_TAGHDR;
                    fidx_next  = '0;
                end
            end
            PH_TAGHDR: begin
                priority if (fidx_reg == 5'd0) begin
                    tstart_next = pos_reg;
                    tkind_next  = data_byte;
                end else if (fidx_reg == 5'd1) begin
                    tsize_next = {16'd0, data_byte};
                end else if (fidx_reg <= 5'd3) begin
                    tsize_next = {tsize_reg[15:0], data_byte};
                end else if (fidx_reg == 5'd4) begin
                    ttime_next = {24'd0, data_byte};
                end else if (fidx_reg <= 5'd6) begin
                    ttime_next = {8'd0, ttime_reg[15:0], data_byte};
                end else if (fidx_reg == 5'd7) begin
                    ttime_next = {ttime_reg[31:24] | data_byte, ttime_reg[23:0]};
                end else begin
                    ttime_next = ttime_reg;
                end
                if (fidx_reg == 5'd10) begin
                    if (tkind_reg == TAG_AUDIO || tkind_reg == TAG_VIDEO) begin
                        if (tsize_reg < need) begin
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_BAD_TAG, '0, '0, '0, '0, 1'b0,
                                                     '0, amax_reg, vmax_reg);
                            phase_next = PH_STOP;
                        end else begin
                            phase_next = PH_SUBHDR;
                            fidx_next  = '0;
                            sub_next   = '0;
                        end
                    end else begin
                        skip_next  = {8'd0, tsize_reg} + 32'd4;
                        phase_next = PH_SKIPBODY;
                    end
                end else begin
                    fidx_next = fi_inc;
                end
            end
            PH_SUBHDR: begin
                sub_next  = sh;
                fidx_next = fi_inc;
                if ({19'd0, fi_inc} >= need) begin
                    phase_next = PH_SKIPBODY;
                    if (tkind_reg == TAG_AUDIO) begin
                        b0        = sh[31:24];
                        b1        = sh[23:16];
                        off       = tstart_reg + OFS_W'(13);
                        skip_next = {8'd0, tsize_reg};
                        if (b0[7:4] != CODEC_AAC) begin
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_BAD_TAG, '0, '0, '0, '0, 1'b0,
                                                     '0, amax_reg, vmax_reg);
                            phase_next = PH_STOP;
                        end else if (b1 == PKT_CONFIG) begin
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_AUDIO_CONFIG, 32'(off),
                                                     tsize_reg - 24'd2, ttime_reg,
                                                     ttime_reg, 1'b0, sh[15:0],
                                                     amax_reg, vmax_reg);
                        end else if (b1 == PKT_FRAME) begin
                            if (ttime_reg > amax_reg) begin
                                amax_next = ttime_reg;
                            end
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_AUDIO_FRAME, 32'(off),
                                                     tsize_reg - 24'd2, ttime_reg,
                                                     ttime_reg, 1'b0, '0,
                                                     amax_next, vmax_reg);
                        end
                    end else begin
                        b0        = sh[39:32];
                        b1        = sh[31:24];
                        off       = tstart_reg + OFS_W'(16);
                        skip_next = {8'd0, tsize_reg} - 32'd1;
                        pts       = ttime_reg + {{8{sh[23]}}, sh[23:0]};
                        if (b0[3:0] != CODEC_AVC) begin
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_BAD_TAG, '0, '0, '0, '0, 1'b0,
                                                     '0, amax_reg, vmax_reg);
                            phase_next = PH_STOP;
                        end else if (b1 == PKT_CONFIG) begin
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_VIDEO_CONFIG, 32'(off),
                                                     tsize_reg - 24'd5, ttime_reg,
                                                     ttime_reg, 1'b0, '0,
                                                     amax_reg, vmax_reg);
                        end else if (b1 == PKT_FRAME) begin
                            if (pts > vmax_reg) begin
                                vmax_next = pts;
                            end
                            main_valid = 1'b1;
                            main_res   = make_result(KIND_VIDEO_FRAME, 32'(off),
                                                     tsize_reg - 24'd5, ttime_reg, pts,
                                                     b0[7:4] == FRAME_KEY, '0,
                                                     amax_reg, vmax_next);
                        end
                    end
                end
            end
            PH_STOP: begin
                phase_next = PH_STOP;
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase

        if (phase_reg != PH_STOP) begin
            pos_next = pos_reg + OFS_W'(1);
        end

        if (last_byte && phase_next != PH_STOP) begin
            end_valid = 1'b1;
            end_res   = make_result((phase_next == PH_HEAD) ? KIND_BAD_SIG : KIND_END,
                                    '0, '0, '0, '0, 1'b0, '0, amax_next, vmax_next);
            end_res.final_res = 1'b1;
            phase_next = PH_STOP;
        end

        push_next.second = end_res;
        if (main_valid) begin
            push_next.first           = main_res;
            push_next.first.final_res = !end_valid;
            push_next.count           = end_valid ? 2'd2 : 2'd1;
        end else begin
            push_next.first = end_res;
            push_next.count = end_valid ? 2'd1 : 2'd0;
        end
    end

    assign push = accept ? push_next : '{count: 2'd0, first: push_next.first,
                                         second: push_next.second};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            pos_reg    <= '0;
            fidx_reg   <= '0;
            tstart_reg <= '0;
            tkind_reg  <= '0;
            tsize_reg  <= '0;
            ttime_reg  <= '0;
            sub_reg    <= '0;
            skip_reg   <= '0;
            amax_reg   <= '0;
            vmax_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            fidx_reg   <= fidx_next;
            tstart_reg <= tstart_next;
            tkind_reg  <= tkind_next;
            tsize_reg  <= tsize_next;
            ttime_reg  <= ttime_next;
            sub_reg    <= sub_next;
            skip_reg   <= skip_next;
            amax_reg   <= amax_next;
            vmax_reg   <= vmax_next;
        end
    end

    a_stop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOP |-> push.count == 2'd0)
        else $error("stopped parser produced a result");

    a_pair_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> push.second.kind == KIND_END && !push.first.final_res)
        else $error("second result of a byte is not the end marker");

    a_single_final: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd1 |-> push.first.final_res)
        else $error("single result lacks final flag");

    a_result_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 && push.first.kind >= KIND_END |=> phase_reg == PH_STOP)
        else $error("parser kept running after end or error");

endmodule
`default_nettype wire

>>> hw/rtl/ftdp_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none
module ftdp_out_fifo
    import ftdp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_data
);

    result_t    entry_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_data  = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next    = wr_reg + push.count;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> {1'b0, count_reg} + {2'b00, push.count} <= 4'd4)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue count out of range");

endmodule
`default_nettype wire

>>> dv/flv_tag_demux_parser_unit_test.sv
// Self-checking FLV tag parser testbench: random and directed FLV streams against a predictor.
module flv_tag_demux_parser_unit_test;
    import ftdp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 720;
    localparam int DUE_DEPTH = 4096;
    localparam logic [7:0] TAG_SCRIPT = 8'd18;
    localparam logic [3:0] FRAME_INTER = 4'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP_FIRST,
        PH_TAG_HEADER,
        PH_SUB_HEADER,
        PH_SKIP_BODY,
        PH_HALTED
    } parse_phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic s_last_byte = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [31:0] m_payload_offset;
    logic [23:0] m_payload_length;
    logic [31:0] m_time_ms;
    logic [31:0] m_presentation_ms;
    logic m_keyframe;
    logic [15:0] m_config_bits;
    logic [31:0] m_audio_duration_ms;
    logic [31:0] m_video_duration_ms;
    logic m_final_res;

    parse_phase_t pr_phase = PH_HEADER;
    logic [31:0] pr_pos = '0;
    logic [4:0] pr_field = '0;
    logic [31:0] pr_first_ofs = '0;
    logic [31:0] pr_tag_start = '0;
    logic [7:0] pr_tag_type = '0;
    logic [23:0] pr_tag_size = '0;
    logic [31:0] pr_tag_time = '0;
    logic [39:0] pr_hdr = '0;
    logic [31:0] pr_skip = '0;
    logic [31:0] pr_audio_max = '0;
    logic [31:0] pr_video_max = '0;

    result_t due_buf [DUE_DEPTH];
    logic [11:0] due_wr = '0;
    logic [11:0] due_rd = '0;
    int due_count = 0;
    result_t pending;
    bit have_pending;

    int mismatch_count = 0;
    int checked_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int rx_stall = 0;
    logic [31:0] ts_base = '0;

    flv_tag_demux_parser_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_payload_offset(m_payload_offset),
        .m_payload_length(m_payload_length),
        .m_time_ms(m_time_ms),
        .m_presentation_ms(m_presentation_ms),
        .m_keyframe(m_keyframe),
        .m_config_bits(m_config_bits),
        .m_audio_duration_ms(m_audio_duration_ms),
        .m_video_duration_ms(m_video_duration_ms),
        .m_final_res(m_final_res)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 299);
        if (r == 0) begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 180) return 0;
        if (r < 270) return $urandom_range(1, 3);
        if (r < 295) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40) begin
            $display("mismatch in %s at descriptor %0d: got %h, expected %h",
                     what, checked_count, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic queue_descr(input result_t r);
        due_buf[due_wr] = r;
        due_wr++;
        due_count++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_count == 0) begin
                report_mismatch("kind of a descriptor with none due", 32'(m_kind), 32'd0);
            end else begin
                want = due_buf[due_rd];
                due_rd++;
                due_count--;
                check_field("kind", 32'(m_kind), 32'(want.kind));
                check_field("payload_offset", m_payload_offset, want.payload_offset);
                check_field("payload_length", 32'(m_payload_length),
                            32'(want.payload_length));
                check_field("time_ms", m_time_ms, want.time_ms);
                check_field("presentation_ms", m_presentation_ms, want.presentation_ms);
                check_field("keyframe", 32'(m_keyframe), 32'(want.keyframe));
                check_field("config_bits", 32'(m_config_bits), 32'(want.config_bits));
                check_field("audio_duration_ms", m_audio_duration_ms,
                            want.audio_duration_ms);
                check_field("video_duration_ms", m_video_duration_ms,
                            want.video_duration_ms);
                check_field("final_res", 32'(m_final_res), 32'(want.final_res));
            end
            checked_count++;
        end
    end

    task automatic emit_descr(input logic [2:0] kind, input logic [31:0] ofs,
                              input logic [23:0] len, input logic [31:0] t,
                              input logic [31:0] p, input logic key,
                              input logic [15:0] cfg);
        if (have_pending) queue_descr(pending);
        pending.kind = kind;
        pending.payload_offset = ofs;
        pending.payload_length = len;
        pending.time_ms = t;
        pending.presentation_ms = p;
        pending.keyframe = key;
        pending.config_bits = cfg;
        pending.audio_duration_ms = pr_audio_max;
        pending.video_duration_ms = pr_video_max;
        pending.final_res = 1'b0;
        have_pending = 1'b1;
    endtask

    task automatic halt_with(input logic [2:0] kind);
        emit_descr(kind, '0, '0, '0, '0, 1'b0, '0);
        pr_phase = PH_HALTED;
    endtask

    task automatic start_tag();
        pr_phase = PH_TAG_HEADER;
        pr_field = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        logic [4:0] need;
        logic [31:0] cts;
        logic [31:0] pts;
        have_pending = 1'b0;
        need = (pr_tag_type == TAG_AUDIO) ? 5'd4 : 5'd5;
        if (pr_phase == PH_HALTED) return;
        case (pr_phase)
            PH_HEADER: begin
                pr_hdr = {pr_hdr[31:0], b};
                if (pr_field == 2 && pr_hdr[23:0] != SIG_FLV) begin
                    halt_with(KIND_BAD_SIG);
                end else if (pr_field == 4 && (b & STREAM_BITS) != STREAM_BITS) begin
                    halt_with(KIND_NO_STREAM);
                end else if (pr_field == 8) begin
                    pr_first_ofs = pr_hdr[31:0] + 32'd4;
                    if (pr_first_ofs > 32'd9) begin
                        pr_skip = pr_first_ofs - 32'd9;
                        pr_phase = PH_SKIP_FIRST;
                    end else begin
                        start_tag();
                    end
                end else begin
                    pr_field++;
                end
            end
            PH_SKIP_FIRST, PH_SKIP_BODY: begin
                pr_skip--;
                if (pr_skip == 0) start_tag();
            end
            PH_TAG_HEADER: begin
                case (pr_field)
                    5'd0: begin
                        pr_tag_start = pr_pos;
                        pr_tag_type = b;
                    end
                    5'd1: pr_tag_size = {16'd0, b};
                    5'd2, 5'd3: pr_tag_size = {pr_tag_size[15:0], b};
                    5'd4: pr_tag_time = {24'd0, b};
                    5'd5, 5'd6: pr_tag_time = {8'd0, pr_tag_time[15:0], b};
                    5'd7: pr_tag_time[31:24] = b;
                    default: ;
                endcase
                if (pr_field == 10) begin
                    if (pr_tag_type == TAG_AUDIO || pr_tag_type == TAG_VIDEO) begin
                        need = (pr_tag_type == TAG_AUDIO) ? 5'd4 : 5'd5;
                        if (pr_tag_size < need) begin
                            halt_with(KIND_BAD_TAG);
                        end else begin
                            pr_phase = PH_SUB_HEADER;
                            pr_field = '0;
                            pr_hdr = '0;
                        end
                    end else begin
                        pr_skip = {8'd0, pr_tag_size} + 32'd4;
                        pr_phase = PH_SKIP_BODY;
                    end
                end else begin
                    pr_field++;
                end
            end
            PH_SUB_HEADER: begin
                pr_hdr = {pr_hdr[31:0], b};
                pr_field++;
                if (pr_field >= need && pr_tag_type == TAG_AUDIO) begin
                    if (pr_hdr[31:28] != CODEC_AAC) begin
                        halt_with(KIND_BAD_TAG);
                    end else begin
                        if (pr_hdr[23:16] == PKT_CONFIG) begin
                            emit_descr(KIND_AUDIO_CONFIG, pr_tag_start + 32'd13,
                                       pr_tag_size - 24'd2, pr_tag_time, pr_tag_time,
                                       1'b0, pr_hdr[15:0]);
                        end else if (pr_hdr[23:16] == PKT_FRAME) begin
                            if (pr_tag_time > pr_audio_max) pr_audio_max = pr_tag_time;
                            emit_descr(KIND_AUDIO_FRAME, pr_tag_start + 32'd13,
                                       pr_tag_size - 24'd2, pr_tag_time, pr_tag_time,
                                       1'b0, 16'd0);
                        end
                        pr_skip = {8'd0, pr_tag_size};
                        pr_phase = PH_SKIP_BODY;
                    end
                end else if (pr_field >= need) begin
                    if (pr_hdr[35:32] != CODEC_AVC) begin
                        halt_with(KIND_BAD_TAG);
                    end else begin
                        cts = {{8{pr_hdr[23]}}, pr_hdr[23:0]};
                        if (pr_hdr[31:24] == PKT_CONFIG) begin
                            emit_descr(KIND_VIDEO_CONFIG, pr_tag_start + 32'd16,
                                       pr_tag_size - 24'd5, pr_tag_time, pr_tag_time,
                                       1'b0, 16'd0);
                        end else if (pr_hdr[31:24] == PKT_FRAME) begin
                            pts = pr_tag_time + cts;
                            if (pts > pr_video_max) pr_video_max = pts;
                            emit_descr(KIND_VIDEO_FRAME, pr_tag_start + 32'd16,
                                       pr_tag_size - 24'd5, pr_tag_time, pts,
                                       pr_hdr[39:36] == FRAME_KEY, 16'd0);
                        end
                        pr_skip = {8'd0, pr_tag_size} - 32'd1;
                        pr_phase = PH_SKIP_BODY;
                    end
                end
            end
            default: pr_phase = PH_HALTED;
        endcase
        pr_pos++;
        if (is_last && pr_phase != PH_HALTED) begin
            if (pr_phase == PH_HEADER) begin
                halt_with(KIND_BAD_SIG);
            end else begin
                halt_with(KIND_END);
            end
        end
        if (have_pending) begin
            pending.final_res = 1'b1;
            queue_descr(pending);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        while (due_count != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic put_tag(input logic [7:0] ttype, input logic [23:0] size,
                           input logic [31:0] ts, input logic [39:0] head,
                           input int last_at);
        int hdr_len;
        int total;
        logic [7:0] b;
        hdr_len = (ttype == TAG_AUDIO) ? 4 : (ttype == TAG_VIDEO) ? 5 : 0;
        total = 11 + int'(size) + 4;
        for (int i = 0; i < total; i++) begin
            case (i)
                0: b = ttype;
                1: b = size[23:16];
                2: b = size[15:8];
                3: b = size[7:0];
                4: b = ts[23:16];
                5: b = ts[15:8];
                6: b = ts[7:0];
                7: b = ts[31:24];
                default: begin
                    if (i >= 11 && i - 11 < hdr_len && i - 11 < int'(size)) begin
                        b = head[8 * (hdr_len - 1 - (i - 11)) +: 8];
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                end
            endcase
            send_byte(b, i == last_at);
        end
    endtask

    function automatic logic [39:0] rand_av_head(input logic [7:0] ttype);
        logic [7:0] pkt;
        logic [3:0] frame;
        logic [23:0] cts;
        int r;
        r = $urandom_range(0, 99);
        pkt = (r < 30) ? PKT_CONFIG : (r < 90) ? PKT_FRAME : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        frame = (r < 40) ? FRAME_KEY : (r < 80) ? FRAME_INTER : 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 5) cts = 24'h800000;
        else if (r < 10) cts = 24'h7fffff;
        else if (r < 15) cts = 24'hffffff;
        else if (r < 20) cts = 24'h000000;
        else cts = 24'($urandom_range(0, 24'hffffff));
        if (ttype == TAG_AUDIO) begin
            return {8'h00, CODEC_AAC, 4'($urandom_range(0, 15)), pkt,
                    16'($urandom_range(0, 16'hffff))};
        end
        return {frame, CODEC_AVC, pkt, cts};
    endfunction

    function automatic logic [23:0] rand_size(input int need);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 24'($urandom_range(need, 16));
        if (r < 97) return 24'($urandom_range(17, 64));
        return 24'($urandom_range(65, 300));
    endfunction

    function automatic logic [31:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            ts_base = ts_base + $urandom_range(0, 50);
            return ts_base;
        end
        if (r < 90) return $urandom();
        return ts_base - $urandom_range(0, 40);
    endfunction

    task automatic test_file_header();
        logic [23:0] sig;
        logic [7:0] flags;
        logic [7:0] drop;
        logic [31:0] data_ofs;
        logic [31:0] first_ofs;
        logic [71:0] hdr;
        int mode;
        int end_at;
        int r;
        mode = $urandom_range(0, 23);
        sig = SIG_FLV;
        flags = 8'($urandom_range(0, 255)) | STREAM_BITS;
        if (mode == 0) begin
            sig[8 * $urandom_range(0, 2) +: 8] ^= 8'($urandom_range(1, 255));
        end else if (mode == 1) begin
            r = $urandom_range(0, 2);
            drop = (r == 0) ? 8'h01 : (r == 1) ? 8'h04 : STREAM_BITS;
            flags = flags & ~drop;
        end
        end_at = (mode == 2) ? $urandom_range(0, 8) : -1;
        r = $urandom_range(0, 9);
        if (r < 5) data_ofs = 32'd9;
        else if (r < 7) data_ofs = $urandom_range(0, 8);
        else if (r < 9) data_ofs = $urandom_range(10, 40);
        else data_ofs = 32'hfffffffc + $urandom_range(0, 3);
        hdr = {sig, 8'($urandom_range(0, 255)), flags, data_ofs};
        for (int i = 0; i < 9; i++) begin
            send_byte(hdr[71 - 8 * i -: 8], i == end_at);
        end
        first_ofs = data_ofs + 32'd4;
        if (first_ofs > 32'd9) begin
            repeat (first_ofs - 32'd9) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_directed_tags();
        put_tag(TAG_AUDIO, 24'd4, 32'd0,
                {8'h00, CODEC_AAC, 4'hf, PKT_CONFIG, 16'hffff}, -1);
        put_tag(TAG_AUDIO, 24'd6, 32'h00000010,
                {8'h00, CODEC_AAC, 4'h0, PKT_CONFIG, 16'h0000}, -1);
        put_tag(TAG_AUDIO, 24'd5, 32'hffffffff,
                {8'h00, CODEC_AAC, 4'h5, PKT_FRAME, 16'ha5a5}, -1);
        put_tag(TAG_AUDIO, 24'd300, 32'd0,
                {8'h00, CODEC_AAC, 4'hf, PKT_FRAME, 16'h1210}, -1);
        put_tag(TAG_AUDIO, 24'd8, 32'h00ff0000,
                {8'h00, CODEC_AAC, 4'h2, 8'hff, 16'h0000}, -1);
        put_tag(TAG_VIDEO, 24'd5, 32'h00001000,
                {FRAME_KEY, CODEC_AVC, PKT_CONFIG, 24'h000000}, -1);
        put_tag(TAG_VIDEO, 24'd9, 32'h00001000,
                {FRAME_KEY, CODEC_AVC, PKT_FRAME, 24'h800000}, -1);
        put_tag(TAG_VIDEO, 24'd6, 32'hffffffff,
                {FRAME_INTER, CODEC_AVC, PKT_FRAME, 24'h7fffff}, -1);
        put_tag(TAG_VIDEO, 24'd5, 32'd0,
                {4'hf, CODEC_AVC, PKT_FRAME, 24'hffffff}, -1);
        put_tag(TAG_VIDEO, 24'd7, 32'h00000200,
                {FRAME_KEY, CODEC_AVC, 8'h02, 24'h000100}, -1);
        put_tag(TAG_VIDEO, 24'd5, 32'h7fffffff,
                {FRAME_KEY, CODEC_AVC, PKT_FRAME, 24'h000000}, -1);
        put_tag(TAG_SCRIPT, 24'd0, 32'd0, '0, -1);
        put_tag(8'hff, 24'd3, 32'd0, '0, -1);
        put_tag(8'h00, 24'd1, 32'd0, '0, -1);
    endtask

    task automatic test_random_tags();
        logic [7:0] ttype;
        logic [23:0] size;
        int stop_at;
        int r;
        wait_drained(4);
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                ttype = TAG_AUDIO;
                size = rand_size(4);
            end else if (r < 8) begin
                ttype = TAG_VIDEO;
                size = rand_size(5);
            end else begin
                do ttype = 8'($urandom_range(0, 255));
                while (ttype == TAG_AUDIO || ttype == TAG_VIDEO);
                if ($urandom_range(0, 1) == 0) ttype = TAG_SCRIPT;
                size = 24'($urandom_range(0, 20));
            end
            put_tag(ttype, size, next_time(), rand_av_head(ttype), -1);
            if ($urandom_range(0, 39) == 0) wait_drained(4);
        end
    endtask

    task automatic test_stream_end();
        logic [7:0] ttype;
        logic [23:0] size;
        logic [39:0] head;
        int need;
        int last_at;
        int mode;
        mode = $urandom_range(0, 5);
        ttype = ($urandom_range(0, 1) == 0) ? TAG_AUDIO : TAG_VIDEO;
        need = (ttype == TAG_AUDIO) ? 4 : 5;
        size = rand_size(need);
        head = rand_av_head(ttype);
        last_at = -1;
        case (mode)
            0: last_at = 11 + int'(size) + 3;
            1: last_at = $urandom_range(0, 11 + int'(size) + 3);
            2: last_at = 10 + need;
            3: begin
                ttype = TAG_AUDIO;
                size = rand_size(4);
                head = rand_av_head(TAG_AUDIO);
                do head[31:28] = 4'($urandom_range(0, 15));
                while (head[31:28] == CODEC_AAC);
            end
            4: begin
                ttype = TAG_VIDEO;
                size = rand_size(5);
                head = rand_av_head(TAG_VIDEO);
                do head[35:32] = 4'($urandom_range(0, 15));
                while (head[35:32] == CODEC_AVC);
            end
            default: size = 24'($urandom_range(0, need - 1));
        endcase
        put_tag(ttype, size, next_time(), head, last_at);
        repeat ($urandom_range(2, 12)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_file_header();
        test_directed_tags();
        test_random_tags();
        test_stream_end();
        wait_drained(12);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ftdp_pkg.sv
hw/rtl/ftdp_parse.sv
hw/rtl/ftdp_out_fifo.sv
hw/rtl/flv_tag_demux_parser_unit.sv
dv/flv_tag_demux_parser_unit_test.sv
